/* rtl/vstl_pkg.sv */
// ----------------------------------------------------------------------------
// vstl_pkg
// shared types and constants of the vector scale-to-length pipeline
// ----------------------------------------------------------------------------
package vstl_pkg;

  localparam int DataW     = 32;
  localparam int CompW     = 24;  // width of a component after the pre-shift
  localparam int ProdW     = 48;
  localparam int SqrtInW   = 44;  // sum of squares times 4096
  localparam int RootW     = SqrtInW / 2;
  localparam int SqrtSteps = RootW;
  localparam int RemW      = RootW + 1;
  localparam int DivDdW    = 44;  // magnitude of a 32-bit word times 4096
  localparam int DivSteps  = DivDdW;
  localparam int ShW       = 4;

  localparam logic [DataW:0]   LimHigh   = 33'd16777216;
  localparam logic [DataW:0]   LimMid    = 33'd1048576;
  localparam logic [ProdW-1:0] QRound    = 48'd2048;
  localparam logic [ShW-1:0]   ShiftHigh = 4'd8;
  localparam logic [ShW-1:0]   ShiftMid  = 4'd4;
  localparam logic [ShW-1:0]   ShiftNone = 4'd0;

  typedef struct packed {
    logic signed [DataW-1:0] vec_x;
    logic signed [DataW-1:0] vec_y;
    logic signed [DataW-1:0] vec_z;
    logic signed [DataW-1:0] target_length;
  } in_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] res_x;
    logic signed [DataW-1:0] res_y;
    logic signed [DataW-1:0] res_z;
  } out_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
    logic signed [DataW-1:0] z;
  } vec_t;

  // travels beside the sum of squares through the root
  typedef struct packed {
    in_word_t       item;
    logic [ShW-1:0] sh;
  } sq_side_t;

  // travels beside a quotient through a divider
  typedef struct packed {
    logic flag;
    vec_t vec;
  } div_side_t;

endpackage

/* rtl/vstl_front.sv */
// ----------------------------------------------------------------------------
// vstl_front
// pre-shift select, component squares and their wrapped sum (3 stages)
// ----------------------------------------------------------------------------
module vstl_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  vstl_pkg::in_word_t word_i,
  output logic              valid_o,
  output logic signed [vstl_pkg::DataW-1:0] sum_o,
  output vstl_pkg::sq_side_t side_o
);
  import vstl_pkg::*;

  function automatic logic is_big(logic signed [DataW-1:0] v, logic [DataW:0] lim);
    logic [DataW:0] ext;
    logic [DataW:0] mag;
    ext = {v[DataW-1], v};
    mag = v[DataW-1] ? (~ext + 33'd1) : ext;
    return mag >= lim;
  endfunction

  logic                    a_v_q, b_v_q, c_v_q;
  logic signed [CompW-1:0] a_c_q [3];
  logic signed [CompW-1:0] a_c_d [3];
  logic        [DataW-1:0] b_sq_q [3];
  logic        [DataW-1:0] b_sq_d [3];
  sq_side_t                a_side_q, b_side_q, c_side_q;
  logic        [ShW-1:0]   sh_d;
  logic signed [DataW-1:0] comp [3];
  logic signed [DataW-1:0] c_sum_q, c_sum_d;

  always_comb begin
    logic signed [DataW-1:0] t;
    comp[0] = word_i.vec_x;
    comp[1] = word_i.vec_y;
    comp[2] = word_i.vec_z;
    if (is_big(comp[0], LimHigh) || is_big(comp[1], LimHigh) || is_big(comp[2], LimHigh)) begin
      sh_d = ShiftHigh;
    end else if (is_big(comp[0], LimMid) || is_big(comp[1], LimMid)
                 || is_big(comp[2], LimMid)) begin
      sh_d = ShiftMid;
    end else begin
      sh_d = ShiftNone;
    end
    for (int i = 0; i < 3; i++) begin
      t = comp[i] >>> sh_d;
      a_c_d[i] = t[CompW-1:0];
    end
  end

  // q12 square with rounding, wrapped to 32 bits
  always_comb begin
    logic signed [ProdW-1:0] p;
    logic        [ProdW-1:0] r;
    for (int i = 0; i < 3; i++) begin
      p = a_c_q[i] * a_c_q[i];
      r = p + QRound;
      b_sq_d[i] = r[DataW+11:12];
    end
  end

  assign c_sum_d = b_sq_q[0] + b_sq_q[1] + b_sq_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_c_q         <= a_c_d;
      a_side_q.item <= word_i;
      a_side_q.sh   <= sh_d;
      b_sq_q        <= b_sq_d;
      b_side_q      <= a_side_q;
      c_sum_q       <= c_sum_d;
      c_side_q      <= b_side_q;
    end
  end

  assign valid_o = c_v_q;
  assign sum_o   = c_sum_q;
  assign side_o  = c_side_q;

endmodule

/* rtl/vstl_sqrt.sv */
// ----------------------------------------------------------------------------
// vstl_sqrt
// q12 square root, one root bit per pipeline stage
// ----------------------------------------------------------------------------
module vstl_sqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic signed [vstl_pkg::DataW-1:0] sum_i,
  input  vstl_pkg::sq_side_t side_i,
  output logic              valid_o,
  output logic [vstl_pkg::RootW-1:0] root_o,
  output vstl_pkg::sq_side_t side_o
);
  import vstl_pkg::*;

  typedef struct packed {
    logic [SqrtInW-1:0] n;
    logic [RemW-1:0]    rem;
    logic [RootW-1:0]   root;
    sq_side_t           side;
  } sqrt_stage_t;

  function automatic sqrt_stage_t step(sqrt_stage_t s);
    sqrt_stage_t    o;
    logic [RemW+1:0] rs;
    logic [RemW+1:0] trial;
    o     = s;
    rs    = {s.rem, s.n[SqrtInW-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    o.n   = {s.n[SqrtInW-3:0], 2'b00};
    if (rs >= trial) begin
      rs     = rs - trial;
      o.root = {s.root[RootW-2:0], 1'b1};
    end else begin
      o.root = {s.root[RootW-2:0], 1'b0};
    end
    o.rem = rs[RemW-1:0];
    return o;
  endfunction

  logic                 ent_v_q;
  sqrt_stage_t          ent_q, ent_d;
  logic [SqrtSteps-1:0] v_q;
  sqrt_stage_t          st_q [SqrtSteps];
  sqrt_stage_t          st_d [SqrtSteps];

  always_comb begin
    ent_d.n    = (sum_i > 0) ? {1'b0, sum_i[DataW-2:0], 12'd0} : '0;
    ent_d.rem  = '0;
    ent_d.root = '0;
    ent_d.side = side_i;
    st_d[0]    = step(ent_q);
    for (int s = 1; s < SqrtSteps; s++) begin
      st_d[s] = step(st_q[s-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= 1'b0;
      v_q     <= '0;
    end else if (en_i) begin
      ent_v_q <= valid_i;
      v_q     <= {v_q[SqrtSteps-2:0], ent_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ent_q <= ent_d;
      st_q  <= st_d;
    end
  end

  assign valid_o = v_q[SqrtSteps-1];
  assign root_o  = st_q[SqrtSteps-1].root;
  assign side_o  = st_q[SqrtSteps-1].side;

endmodule

/* rtl/vstl_div.sv */
// ----------------------------------------------------------------------------
// vstl_div
// signed q12 divide (a * 4096) / b, truncating, one quotient bit per stage
// ----------------------------------------------------------------------------
module vstl_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [vstl_pkg::DataW-1:0] dividend_i,
  input  logic signed [vstl_pkg::DataW-1:0] divisor_i,
  input  vstl_pkg::div_side_t side_i,
  output logic               valid_o,
  output logic signed [vstl_pkg::DataW-1:0] quot_o,
  output vstl_pkg::div_side_t side_o
);
  import vstl_pkg::*;

  typedef struct packed {
    logic [DivDdW-1:0] dd;
    logic [DataW-1:0]  rem;
    logic [DataW-1:0]  quo;
    logic [DataW-1:0]  dv;
    logic              neg;
    logic              zero;
    div_side_t         side;
  } div_stage_t;

  function automatic div_stage_t step(div_stage_t s);
    div_stage_t     o;
    logic [DataW:0] rs;
    logic [DataW:0] dx;
    logic           ge;
    o    = s;
    rs   = {s.rem, s.dd[DivDdW-1]};
    dx   = {1'b0, s.dv};
    ge   = rs >= dx;
    if (ge) begin
      rs = rs - dx;
    end
    o.rem = rs[DataW-1:0];
    o.quo = {s.quo[DataW-2:0], ge};
    o.dd  = {s.dd[DivDdW-2:0], 1'b0};
    return o;
  endfunction

  logic                ent_v_q, out_v_q;
  div_stage_t          ent_q, ent_d;
  logic [DivSteps-1:0] v_q;
  div_stage_t          st_q [DivSteps];
  div_stage_t          st_d [DivSteps];
  logic [DataW-1:0]    mag_a, mag_b;
  logic signed [DataW-1:0] quot_q, quot_d;
  div_side_t           side_q;
  div_stage_t          last;

  always_comb begin
    mag_a      = dividend_i[DataW-1] ? (~dividend_i + 32'd1) : dividend_i;
    mag_b      = divisor_i[DataW-1] ? (~divisor_i + 32'd1) : divisor_i;
    ent_d.dd   = {mag_a, 12'd0};
    ent_d.rem  = '0;
    ent_d.quo  = '0;
    ent_d.dv   = mag_b;
    ent_d.neg  = dividend_i[DataW-1] ^ divisor_i[DataW-1];
    ent_d.zero = (divisor_i == '0);
    ent_d.side = side_i;
    st_d[0]    = step(ent_q);
    for (int s = 1; s < DivSteps; s++) begin
      st_d[s] = step(st_q[s-1]);
    end
    last = st_q[DivSteps-1];
    if (last.zero) begin
      quot_d = '0;
    end else if (last.neg) begin
      quot_d = ~last.quo + 32'd1;
    end else begin
      quot_d = last.quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= 1'b0;
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      ent_v_q <= valid_i;
      v_q     <= {v_q[DivSteps-2:0], ent_v_q};
      out_v_q <= v_q[DivSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ent_q  <= ent_d;
      st_q   <= st_d;
      quot_q <= quot_d;
      side_q <= last.side;
    end
  end

  assign valid_o = out_v_q;
  assign quot_o  = quot_q;
  assign side_o  = side_q;

endmodule

/* rtl/vector_scale_to_length.sv */
// ----------------------------------------------------------------------------
// vector_scale_to_length
// rescales a q12 3d vector so that its length becomes a target length
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o carry one word holding vec_x,
//   vec_y, vec_z and target_length, all signed q12
//   output channel: out_valid_o / out_stall_i carry one word holding
//   res_x, res_y, res_z; every input word gives exactly one output word
//   throughput: one word per cycle while no output word is held under out_stall_i
//   path: from acceptance to out_valid_o a word passes the front end,
//   the bit-serial root, the scale divider, the component dividers and
//   the output register
//   stall: the whole pipeline holds while an output word waits under
//   out_stall_i; in_stall_o rises in that same cycle, nothing is dropped
//   reset: all valid bits clear, the pipeline comes up empty and ready
// ----------------------------------------------------------------------------
module vector_scale_to_length (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vstl_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vstl_pkg::out_word_t out_word_o
);
  import vstl_pkg::*;

  // global advance: every stage moves unless the output word is held
  logic en;

  logic                    fr_v;
  logic signed [DataW-1:0] fr_sum;
  sq_side_t                fr_side;

  logic                    rt_v;
  logic [RootW-1:0]        rt_root;
  sq_side_t                rt_side;
  logic [DataW-1:0]        root_ext;
  logic signed [DataW-1:0] scale_dd;
  div_side_t               sc_side_in;

  logic                    sc_v;
  logic signed [DataW-1:0] scale;
  div_side_t               sc_side;
  div_side_t               ln_side_in;

  logic                    l0_v, l1_v, l2_v;
  logic signed [DataW-1:0] l0_q, l1_q, l2_q;
  div_side_t               l0_side, l1_side, l2_side;

  logic                    out_valid_q;
  out_word_t               out_word_q, out_word_d;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // pre-shift, squares, sum of squares
  vstl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .word_i  (in_word_i),
    .valid_o (fr_v),
    .sum_o   (fr_sum),
    .side_o  (fr_side)
  );

  // length of the shifted vector, zero when the sum is not positive
  vstl_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .sum_i   (fr_sum),
    .side_i  (fr_side),
    .valid_o (rt_v),
    .root_o  (rt_root),
    .side_o  (rt_side)
  );

  // undo the pre-shift on the root, then scale = root / target_length
  always_comb begin
    root_ext         = {{(DataW-RootW){1'b0}}, rt_root};
    scale_dd         = root_ext << rt_side.sh;
    sc_side_in.flag  = 1'b0;
    sc_side_in.vec.x = rt_side.item.vec_x;
    sc_side_in.vec.y = rt_side.item.vec_y;
    sc_side_in.vec.z = rt_side.item.vec_z;
  end

  vstl_div u_div_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (rt_v),
    .dividend_i (scale_dd),
    .divisor_i  (rt_side.item.target_length),
    .side_i     (sc_side_in),
    .valid_o    (sc_v),
    .quot_o     (scale),
    .side_o     (sc_side)
  );

  // flag marks a positive scale; otherwise the word passes through
  always_comb begin
    ln_side_in.flag = !scale[DataW-1] && (scale != '0);
    ln_side_in.vec  = sc_side.vec;
  end

  vstl_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (sc_v),
    .dividend_i (sc_side.vec.x),
    .divisor_i  (scale),
    .side_i     (ln_side_in),
    .valid_o    (l0_v),
    .quot_o     (l0_q),
    .side_o     (l0_side)
  );

  vstl_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (sc_v),
    .dividend_i (sc_side.vec.y),
    .divisor_i  (scale),
    .side_i     (ln_side_in),
    .valid_o    (l1_v),
    .quot_o     (l1_q),
    .side_o     (l1_side)
  );

  vstl_div u_div_z (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (sc_v),
    .dividend_i (sc_side.vec.z),
    .divisor_i  (scale),
    .side_i     (ln_side_in),
    .valid_o    (l2_v),
    .quot_o     (l2_q),
    .side_o     (l2_side)
  );

  // pick quotient or original component per lane
  always_comb begin
    out_word_d.res_x = l0_side.flag ? l0_q : l0_side.vec.x;
    out_word_d.res_y = l1_side.flag ? l1_q : l1_side.vec.y;
    out_word_d.res_z = l2_side.flag ? l2_q : l2_side.vec.z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= l0_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // the three component lanes run in lockstep
  a_lanes_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (l0_v == l1_v) && (l0_v == l2_v))
    else $error("component divider lanes out of step");

  // lanes see the same pass-through decision
  a_flags_agree : assert property (@(posedge clk_i) disable iff (!rst_ni)
    l0_v |-> (l0_side.flag == l1_side.flag) && (l0_side.flag == l2_side.flag))
    else $error("pass-through flag differs between lanes");

  // input is held off only by a waiting output word
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held output word");

  // a frozen pipeline keeps its output word
  a_hold_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(out_word_o))
    else $error("held output word changed");

endmodule
